[src/olcs_pkg.sv]
// ----------------------------------------------------------------------------
// olcs_pkg
// Types, codes and constants shared by the lane-change sequencer files.
// ----------------------------------------------------------------------------
package olcs_pkg;

    localparam int unsigned DIST_W  = 16;
    localparam int unsigned HCM_W   = 9;   // class height in cm, up to 400
    localparam int unsigned FOCAL_W = 12;
    localparam int unsigned BH_W    = 11;
    localparam int unsigned PROD_W  = HCM_W + FOCAL_W;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned CMD_W   = 13;

    localparam logic [DIST_W-1:0] SAT_DIST_CM = '1;

    localparam logic signed [CMD_W-1:0] CMD_LIMIT     = 13'sd4000;
    localparam logic signed [CMD_W-1:0] OVR_SPEED     = 13'sd250;
    localparam logic signed [CMD_W-1:0] SHIFT_STEER   = 13'sd550;
    localparam logic signed [CMD_W-1:0] REALIGN_STEER = 13'sd413;

    typedef enum logic [1:0] {
        CMD_BOX       = 2'd0,
        CMD_FRAME_END = 2'd1,
        CMD_LANE_TICK = 2'd2,
        CMD_UNUSED    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_SHIFTING = 2'd1,
        MODE_REALIGN  = 2'd2,
        MODE_CHANGED  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        REG_DANGER   = 3'd0,
        REG_CLEAR    = 3'd1,
        REG_HOLD     = 3'd2,
        REG_REALIGN  = 3'd3,
        REG_TIMEOUT  = 3'd4,
        REG_FOCAL    = 3'd5,
        REG_WIDTH    = 3'd6,
        REG_ZONE     = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        DU_IDLE,
        DU_MUL,
        DU_DIV,
        DU_FIN
    } t_du_state;

    typedef enum logic {
        ST_IDLE,
        ST_DIST
    } t_seq_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_du_status;

    function automatic logic [HCM_W-1:0] class_height_cm(input logic [6:0] cls);
        logic [HCM_W-1:0] h;
        case (cls)
            7'd0:    h = 9'd175;
            7'd1:    h = 9'd100;
            7'd2:    h = 9'd150;
            7'd3:    h = 9'd120;
            7'd5:    h = 9'd350;
            7'd7:    h = 9'd400;
            7'd9:    h = 9'd90;
            7'd11:   h = 9'd80;
            default: h = 9'd120;
        endcase
        return h;
    endfunction

    function automatic logic signed [CMD_W-1:0] clamp_cmd(input logic signed [CMD_W-1:0] v);
        logic signed [CMD_W-1:0] r;
        if (v > CMD_LIMIT) begin
            r = CMD_LIMIT;
        end else if (v < -CMD_LIMIT) begin
            r = -CMD_LIMIT;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[src/olcs_dist_unit.sv]
// ----------------------------------------------------------------------------
// olcs_dist_unit
// Bit-serial distance estimate: height x focal by shift-add, then restoring
// division by box height one quotient bit a cycle, saturated to 16 bits.
// ----------------------------------------------------------------------------
module olcs_dist_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [olcs_pkg::HCM_W-1:0]        i_height_cm,
    input  logic [olcs_pkg::FOCAL_W-1:0]      i_focal_px,
    input  logic [olcs_pkg::BH_W-1:0]         i_box_height,
    output olcs_pkg::t_du_status              o_status,
    output logic [olcs_pkg::DIST_W-1:0]       o_dist_cm
);

    olcs_pkg::t_du_state r_state, n_state;
    logic [olcs_pkg::CNT_W-1:0]   r_cnt;
    logic [olcs_pkg::HCM_W-1:0]   r_hcm;
    logic [olcs_pkg::FOCAL_W-1:0] r_focal;
    logic [olcs_pkg::BH_W-1:0]    r_div;
    logic [olcs_pkg::BH_W-1:0]    r_rem;
    logic [olcs_pkg::PROD_W-1:0]  r_prod;   // product, then quotient

    logic [olcs_pkg::BH_W:0]      w_trial;
    logic [olcs_pkg::BH_W:0]      w_diff;
    logic                         w_ge;
    logic [olcs_pkg::PROD_W-1:0]  w_addend;

    assign w_trial  = {r_rem, r_prod[olcs_pkg::PROD_W-1]};
    assign w_ge     = w_trial >= {1'b0, r_div};
    assign w_diff   = w_trial - {1'b0, r_div};
    assign w_addend = r_hcm[olcs_pkg::HCM_W-1]
                    ? {{(olcs_pkg::PROD_W-olcs_pkg::FOCAL_W){1'b0}}, r_focal}
                    : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            olcs_pkg::DU_IDLE: if (i_start)      n_state = olcs_pkg::DU_MUL;
            olcs_pkg::DU_MUL:  if (r_cnt == '0)  n_state = olcs_pkg::DU_DIV;
            olcs_pkg::DU_DIV:  if (r_cnt == '0)  n_state = olcs_pkg::DU_FIN;
            olcs_pkg::DU_FIN:                    n_state = olcs_pkg::DU_IDLE;
            default:                             n_state = olcs_pkg::DU_IDLE;
        endcase
    end

    always_comb begin
        o_status.busy = (r_state != olcs_pkg::DU_IDLE);
        o_status.done = (r_state == olcs_pkg::DU_FIN);
        if (r_prod[olcs_pkg::PROD_W-1:olcs_pkg::DIST_W] != '0) begin
            o_dist_cm = olcs_pkg::SAT_DIST_CM;
        end else begin
            o_dist_cm = r_prod[olcs_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olcs_pkg::DU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            olcs_pkg::DU_IDLE: begin
                r_hcm   <= i_height_cm;
                r_focal <= i_focal_px;
                r_div   <= i_box_height;
                r_prod  <= '0;
                r_rem   <= '0;
                r_cnt   <= olcs_pkg::CNT_W'(olcs_pkg::HCM_W - 1);
            end
            olcs_pkg::DU_MUL: begin
                r_prod <= {r_prod[olcs_pkg::PROD_W-2:0], 1'b0} + w_addend;
                r_hcm  <= {r_hcm[olcs_pkg::HCM_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    r_cnt <= olcs_pkg::CNT_W'(olcs_pkg::PROD_W - 1);
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            olcs_pkg::DU_DIV: begin
                r_rem  <= w_ge ? w_diff[olcs_pkg::BH_W-1:0] : w_trial[olcs_pkg::BH_W-1:0];
                r_prod <= {r_prod[olcs_pkg::PROD_W-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

[src/obstacle_lane_change_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// obstacle_lane_change_sequencer_unit
// Keeps the nearest in-path obstacle per frame and steps the avoidance modes
// on each lane command, passing the command through or overriding it.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------
//  input     | in        | i_valid / o_stall       | cmd, box, class, time, lane cmd
//  result    | out       | o_valid / i_stall       | speed, steer, override, mode, dist
//  config    | in        | i_cfg_valid/o_cfg_ready | register index, data
//
//  Lane ticks, frame ends, unused codes and out-of-zone boxes do not use the distance unit.
//  An in-zone box with non-zero height is accepted, then goes through the serial
//  multiply and the one-bit-a-cycle divider, then finishes.
//  Reset (synchronous, active low) loads the register defaults and state.
//  Input is stalled while a distance is in work or a result waits stalled.
// ----------------------------------------------------------------------------
module obstacle_lane_change_sequencer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic [10:0]        i_box_center_x,
    input  logic [10:0]        i_box_height,
    input  logic [6:0]         i_class_id,
    input  logic [31:0]        i_now_ms,
    input  logic signed [12:0] i_lane_speed_mms,
    input  logic signed [12:0] i_lane_steer_mrad,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [12:0] o_speed_mms,
    output logic signed [12:0] o_steer_mrad,
    output logic               o_overridden,
    output logic [1:0]         o_mode,
    output logic [15:0]        o_nearest_cm,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    // configuration
    logic [15:0] r_danger, r_clear, r_hold, r_realign, r_timeout;
    logic [11:0] r_focal;
    logic [10:0] r_width, r_zone;

    // state
    olcs_pkg::t_mode      r_mode;
    logic [31:0]          r_phase_start;
    logic [15:0]          r_nearest;
    logic                 r_shift_right;
    logic [15:0]          r_best_cm;
    logic                 r_best_found;
    logic [10:0]          r_best_center;
    logic [10:0]          r_bx;

    olcs_pkg::t_seq_state r_state, n_state;
    logic                 r_out_valid;

    logic                 w_accept;
    logic                 w_start;
    logic [10:0]          w_centre;
    logic [10:0]          w_off;
    logic                 w_in_zone;
    olcs_pkg::t_du_status w_du;
    logic [15:0]          w_du_dist;

    // lane step
    logic [31:0]               w_elapsed;
    logic                      w_hold_over, w_realign_over, w_timeout_over;
    olcs_pkg::t_mode           n_mode;
    logic                      n_phase_load;
    logic signed [12:0]        n_speed, n_steer;
    logic                      n_ovr;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != olcs_pkg::ST_IDLE) || (r_out_valid && i_stall);
    assign w_accept    = i_valid && !o_stall;
    assign o_valid     = r_out_valid;

    assign w_centre  = {1'b0, r_width[10:1]};
    assign w_off     = (i_box_center_x >= w_centre) ? (i_box_center_x - w_centre)
                                                    : (w_centre - i_box_center_x);
    assign w_in_zone = (w_off <= r_zone);

    // ---------------------------------------------------------------- control
    always_comb begin
        n_state = r_state;
        case (r_state)
            olcs_pkg::ST_IDLE: if (w_start)       n_state = olcs_pkg::ST_DIST;
            olcs_pkg::ST_DIST: if (w_du.done)     n_state = olcs_pkg::ST_IDLE;
            default:                              n_state = olcs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_start = 1'b0;
        case (r_state)
            olcs_pkg::ST_IDLE: begin
                w_start = w_accept && (i_cmd == olcs_pkg::CMD_BOX) && w_in_zone
                          && (i_box_height != '0) && !w_du.busy;
            end
            default: w_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olcs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    olcs_dist_unit u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_height_cm  (olcs_pkg::class_height_cm(i_class_id)),
        .i_focal_px   (r_focal),
        .i_box_height (i_box_height),
        .o_status     (w_du),
        .o_dist_cm    (w_du_dist)
    );

    // -------------------------------------------------------------- lane step
    assign w_elapsed      = i_now_ms - r_phase_start;
    assign w_hold_over    = (w_elapsed[31:16] != '0) || (w_elapsed[15:0] > r_hold);
    assign w_realign_over = (w_elapsed[31:16] != '0) || (w_elapsed[15:0] > r_realign);
    assign w_timeout_over = (w_elapsed[31:16] != '0) || (w_elapsed[15:0] > r_timeout);

    always_comb begin
        n_mode       = r_mode;
        n_phase_load = 1'b0;
        n_speed      = olcs_pkg::clamp_cmd(i_lane_speed_mms);
        n_steer      = olcs_pkg::clamp_cmd(i_lane_steer_mrad);
        n_ovr        = 1'b0;
        case (r_mode)
            olcs_pkg::MODE_NORMAL: begin
                if (r_nearest < r_danger) begin
                    n_mode       = olcs_pkg::MODE_SHIFTING;
                    n_phase_load = 1'b1;
                end
            end
            olcs_pkg::MODE_SHIFTING: begin
                n_speed = olcs_pkg::OVR_SPEED;
                n_steer = r_shift_right ? olcs_pkg::SHIFT_STEER : -olcs_pkg::SHIFT_STEER;
                n_ovr   = 1'b1;
                if (w_hold_over) begin
                    n_mode       = olcs_pkg::MODE_REALIGN;
                    n_phase_load = 1'b1;
                end
            end
            olcs_pkg::MODE_REALIGN: begin
                n_speed = olcs_pkg::OVR_SPEED;
                n_steer = r_shift_right ? -olcs_pkg::REALIGN_STEER : olcs_pkg::REALIGN_STEER;
                n_ovr   = 1'b1;
                if (w_realign_over) begin
                    n_mode       = olcs_pkg::MODE_CHANGED;
                    n_phase_load = 1'b1;
                end
            end
            default: begin
                // changed mode leaves without reloading the phase start
                if ((r_nearest > r_clear) || w_timeout_over) begin
                    n_mode = olcs_pkg::MODE_NORMAL;
                end
            end
        endcase
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_danger      <= 16'd350;
            r_clear       <= 16'd550;
            r_hold        <= 16'd1200;
            r_realign     <= 16'd900;
            r_timeout     <= 16'd6000;
            r_focal       <= 12'd381;
            r_width       <= 11'd640;
            r_zone        <= 11'd192;
            r_mode        <= olcs_pkg::MODE_NORMAL;
            r_phase_start <= '0;
            r_nearest     <= olcs_pkg::SAT_DIST_CM;
            r_shift_right <= 1'b1;
            r_best_cm     <= olcs_pkg::SAT_DIST_CM;
            r_best_found  <= 1'b0;
            r_best_center <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    olcs_pkg::REG_DANGER:  r_danger  <= i_cfg_data;
                    olcs_pkg::REG_CLEAR:   r_clear   <= i_cfg_data;
                    olcs_pkg::REG_HOLD:    r_hold    <= i_cfg_data;
                    olcs_pkg::REG_REALIGN: r_realign <= i_cfg_data;
                    olcs_pkg::REG_TIMEOUT: r_timeout <= i_cfg_data;
                    olcs_pkg::REG_FOCAL:   r_focal   <= i_cfg_data[11:0];
                    olcs_pkg::REG_WIDTH:   r_width   <= i_cfg_data[10:0];
                    olcs_pkg::REG_ZONE:    r_zone    <= i_cfg_data[10:0];
                    default: begin
                    end
                endcase
            end

            // a new tick result replaces the one leaving in the same cycle
            if (w_accept && (i_cmd == olcs_pkg::CMD_LANE_TICK)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (w_accept) begin
                case (i_cmd)
                    olcs_pkg::CMD_BOX: begin
                        // in-zone zero height saturates at once; other in-zone boxes go to the divider
                        if (w_in_zone && (i_box_height == '0)) begin
                            if (!r_best_found) begin
                                r_best_cm     <= olcs_pkg::SAT_DIST_CM;
                                r_best_center <= i_box_center_x;
                                r_best_found  <= 1'b1;
                            end
                        end
                    end
                    olcs_pkg::CMD_FRAME_END: begin
                        r_nearest <= r_best_cm;
                        if (r_best_found) begin
                            r_shift_right <= (r_best_center < w_centre);
                        end
                        r_best_cm    <= olcs_pkg::SAT_DIST_CM;
                        r_best_found <= 1'b0;
                    end
                    olcs_pkg::CMD_LANE_TICK: begin
                        r_mode <= n_mode;
                        if (n_phase_load) begin
                            r_phase_start <= i_now_ms;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if ((r_state == olcs_pkg::ST_DIST) && w_du.done) begin
                if (!r_best_found || (w_du_dist < r_best_cm)) begin
                    r_best_cm     <= w_du_dist;
                    r_best_center <= r_bx;
                    r_best_found  <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_bx <= i_box_center_x;
        end
        if (w_accept && (i_cmd == olcs_pkg::CMD_LANE_TICK)) begin
            o_speed_mms  <= n_speed;
            o_steer_mrad <= n_steer;
            o_overridden <= n_ovr;
            o_mode       <= n_mode;
            o_nearest_cm <= r_nearest;
        end
    end

endmodule

[src/olcs_checker.sv]
// ----------------------------------------------------------------------------
// olcs_checker
// Port-level checks on the sequencer results, bound to the top level.
// ----------------------------------------------------------------------------
module olcs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [12:0] o_speed_mms,
    input logic signed [12:0] o_steer_mrad,
    input logic               o_overridden,
    input logic [1:0]         o_mode
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // override only comes from shifting or realigning, so is never reported in normal mode
    a_ovr_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overridden |-> o_mode != olcs_pkg::MODE_NORMAL)
        else $error("override reported in normal mode");

    // realigning is only reached from shifting, which overrides
    a_pass_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_overridden |-> o_mode != olcs_pkg::MODE_REALIGN)
        else $error("pass-through reported in realign mode");

    a_ovr_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overridden |-> o_speed_mms == olcs_pkg::OVR_SPEED &&
        (o_steer_mrad == olcs_pkg::SHIFT_STEER || o_steer_mrad == -olcs_pkg::SHIFT_STEER ||
         o_steer_mrad == olcs_pkg::REALIGN_STEER || o_steer_mrad == -olcs_pkg::REALIGN_STEER))
        else $error("override command values wrong");

    a_pass_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_overridden |->
        o_speed_mms <= olcs_pkg::CMD_LIMIT && o_speed_mms >= -olcs_pkg::CMD_LIMIT &&
        o_steer_mrad <= olcs_pkg::CMD_LIMIT && o_steer_mrad >= -olcs_pkg::CMD_LIMIT)
        else $error("pass-through command not saturated");

endmodule

bind obstacle_lane_change_sequencer_unit olcs_checker u_olcs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_speed_mms  (o_speed_mms),
    .o_steer_mrad (o_steer_mrad),
    .o_overridden (o_overridden),
    .o_mode       (o_mode)
);
